// ----- design/cfpr_pkg.sv -----
// Shared types, constants and CRC function for the framed packet receiver.
`default_nettype none

package cfpr_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int HDR_CNT_W    = 4;
  localparam int PAY_CNT_W    = 7;
  localparam int LEN_W        = 16;
  localparam int CRC_W        = 16;
  localparam int OFFSET_W     = 6;
  localparam int CNT_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0]           MAGIC_FIRST_RST = 8'hA5;
  localparam logic [7:0]           MAGIC_SECOND_RST = 8'h5A;
  localparam logic [PAY_CNT_W-1:0] MAX_PAYLOAD_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MAGIC2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRCLO,
    PH_CRCHI,
    PH_RESYNC,
    PH_RESYNC2,
    PH_EMIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_TEXT          = 3'd0,
    ST_CONSUMED      = 3'd1,
    ST_SYNC_CONSUMED = 3'd2,
    ST_SYNC_TEXT     = 3'd3,
    ST_LEN_ERR       = 3'd4,
    ST_CRC_ERR       = 3'd5,
    ST_READY         = 3'd6
  } status_t;

  typedef struct packed {
    logic    hdr_wr;
    logic    pay_wr;
    logic    crc_lo_wr;
    logic    frame_start;
    logic    inc_sync;
    logic    inc_len;
    logic    inc_crc;
    logic    inc_frame;
    logic    out_load;
    status_t out_status;
    logic    emit_start;
    logic    emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic eq_first;
    logic eq_second;
    logic hdr_last;
    logic len_bad;
    logic len_zero;
    logic pay_last;
    logic crc_ok;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

  // Bitwise CRC-16/CCITT-FALSE over one byte, MSB first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/cfpr_if.sv -----
// Byte input and result output channel interfaces.
`default_nettype none

interface cfpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] header_word;
  logic [15:0] request_tag;
  logic [6:0]  frame_payload_length;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_offset;
  logic        last_of_run;
  logic [31:0] frames_count;
  logic [31:0] sync_error_count;
  logic [31:0] crc_error_count;
  logic [31:0] length_error_count;

  modport source (output valid, output status, output header_word, output request_tag,
                  output frame_payload_length, output payload_byte, output payload_offset,
                  output last_of_run, output frames_count, output sync_error_count,
                  output crc_error_count, output length_error_count, input ready);
  modport sink (input valid, input status, input header_word, input request_tag,
                input frame_payload_length, input payload_byte, input payload_offset,
                input last_of_run, input frames_count, input sync_error_count,
                input crc_error_count, input length_error_count, output ready);
endinterface

`default_nettype wire

// ----- design/crc_framed_packet_receiver.sv -----
// A byte's result is in the output register in the cycle after its transaction.
// Throughput: one byte per cycle while in_ready is high; CRC update is in that cycle.
// A good frame holds off input after its CRC byte while the payload store is read
// out, one result per cycle unless the output stalls; a zero length gives one result.
// Reset (synchronous, rst_n low) idles the parser, clears counters and loads
// the default magic bytes and payload limit; the stores need no clearing pass.
`default_nettype none

module crc_framed_packet_receiver #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cfpr_rx_if.sink                             in_ch,
  cfpr_res_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cfpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfpr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cfpr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfpr_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .stat                     (stat),
    .rx_byte                  (in_ch.rx_byte),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .out_ready                (out_ch.ready),
    .out_valid                (out_ch.valid),
    .out_status               (out_ch.status),
    .out_header_word          (out_ch.header_word),
    .out_request_tag          (out_ch.request_tag),
    .out_frame_payload_length (out_ch.frame_payload_length),
    .out_payload_byte         (out_ch.payload_byte),
    .out_payload_offset       (out_ch.payload_offset),
    .out_last_of_run          (out_ch.last_of_run),
    .out_frames_count         (out_ch.frames_count),
    .out_sync_error_count     (out_ch.sync_error_count),
    .out_crc_error_count      (out_ch.crc_error_count),
    .out_length_error_count   (out_ch.length_error_count)
  );

endmodule

`default_nettype wire

// ----- design/cfpr_ctrl.sv -----
// Frame parsing state machine: decodes phase and issues datapath commands.
`default_nettype none

module cfpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfpr_pkg::dp_stat_t stat,
  output cfpr_pkg::dp_cmd_t  cmd
);
  import cfpr_pkg::*;

  phase_t state_r;
  phase_t state_nxt;
  logic   acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = ST_CONSUMED;
    state_nxt      = state_r;
    in_ready       = (state_r != PH_EMIT) && stat.out_free;
    acc            = in_valid && in_ready;

    if (state_r == PH_EMIT) begin
      // Drain one payload result per free output slot.
      if (stat.out_free) begin
        cmd.emit_load = 1'b1;
        if (stat.emit_last) begin
          state_nxt = PH_IDLE;
        end
      end
    end else if (acc) begin
      cmd.out_load = 1'b1;
      case (state_r)
        PH_IDLE: begin
          if (stat.eq_first) begin
            state_nxt = PH_MAGIC2;
          end else begin
            cmd.out_status = ST_TEXT;
          end
        end
        PH_MAGIC2: begin
          if (stat.eq_second) begin
            cmd.frame_start = 1'b1;
            state_nxt       = PH_HEADER;
          end else begin
            cmd.inc_sync = 1'b1;
            if (stat.eq_first) begin
              cmd.out_status = ST_SYNC_CONSUMED;
            end else begin
              cmd.out_status = ST_SYNC_TEXT;
              state_nxt      = PH_IDLE;
            end
          end
        end
        PH_HEADER: begin
          cmd.hdr_wr = 1'b1;
          if (stat.hdr_last) begin
            if (stat.len_bad) begin
              cmd.inc_len    = 1'b1;
              cmd.out_status = ST_LEN_ERR;
              state_nxt      = PH_RESYNC;
            end else if (stat.len_zero) begin
              state_nxt = PH_CRCLO;
            end else begin
              state_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          cmd.pay_wr = 1'b1;
          if (stat.pay_last) begin
            state_nxt = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          cmd.crc_lo_wr = 1'b1;
          state_nxt     = PH_CRCHI;
        end
        PH_CRCHI: begin
          if (stat.crc_ok) begin
            // Results come from the burst, not from this transaction.
            cmd.out_load   = 1'b0;
            cmd.inc_frame  = 1'b1;
            cmd.emit_start = 1'b1;
            state_nxt      = PH_EMIT;
          end else begin
            cmd.inc_crc    = 1'b1;
            cmd.out_status = ST_CRC_ERR;
            state_nxt      = PH_IDLE;
          end
        end
        PH_RESYNC: begin
          if (stat.eq_first) begin
            state_nxt = PH_RESYNC2;
          end
        end
        PH_RESYNC2: begin
          if (stat.eq_second) begin
            cmd.frame_start = 1'b1;
            state_nxt       = PH_HEADER;
          end else if (!stat.eq_first) begin
            state_nxt = PH_RESYNC;
          end
        end
        default: begin
          state_nxt = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cfpr_datapath.sv -----
// Datapath: CRC, header and payload stores, event counters, result register.
`default_nettype none

module cfpr_datapath #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  cfpr_pkg::dp_cmd_t                       cmd,
  output cfpr_pkg::dp_stat_t                      stat,
  input  logic [7:0]                              rx_byte,
  input  logic                                    cfg_we,
  input  logic [cfpr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cfpr_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [2:0]                              out_status,
  output logic [31:0]                             out_header_word,
  output logic [15:0]                             out_request_tag,
  output logic [cfpr_pkg::PAY_CNT_W-1:0]          out_frame_payload_length,
  output logic [7:0]                              out_payload_byte,
  output logic [cfpr_pkg::OFFSET_W-1:0]           out_payload_offset,
  output logic                                    out_last_of_run,
  output logic [cfpr_pkg::CNT_W-1:0]              out_frames_count,
  output logic [cfpr_pkg::CNT_W-1:0]              out_sync_error_count,
  output logic [cfpr_pkg::CNT_W-1:0]              out_crc_error_count,
  output logic [cfpr_pkg::CNT_W-1:0]              out_length_error_count
);
  import cfpr_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [PAY_CNT_W-1:0] DEPTH_C = PAY_CNT_W'(PAYLOAD_DEPTH);

  // Configuration
  logic [7:0]           magic_first_r;
  logic [7:0]           magic_second_r;
  logic [PAY_CNT_W-1:0] max_payload_r;

  // Frame state
  logic [7:0]           hdr_r [HEADER_BYTES];
  logic [7:0]           pay_mem [PAYLOAD_DEPTH];
  logic [HDR_CNT_W-1:0] header_count_r;
  logic [PAY_CNT_W-1:0] payload_count_r;
  logic [PAY_CNT_W-1:0] payload_count_nxt;
  logic [LEN_W-1:0]     length_r;
  logic [CRC_W-1:0]     crc_r;
  logic [7:0]           crc_low_r;
  logic [OFFSET_W-1:0]  emit_idx_r;

  // Counters
  logic [CNT_W-1:0] frames_r;
  logic [CNT_W-1:0] sync_err_r;
  logic [CNT_W-1:0] crc_err_r;
  logic [CNT_W-1:0] len_err_r;

  // Result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [7:0]          out_byte_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic                out_last_r;

  logic [PAY_CNT_W-1:0] limit;
  logic [LEN_W-1:0]     len_hdr;
  logic [PAY_CNT_W-1:0] emit_end;
  logic                 ready_res;

  assign limit             = (max_payload_r > DEPTH_C) ? DEPTH_C : max_payload_r;
  assign len_hdr           = {rx_byte, hdr_r[6]};
  assign payload_count_nxt = payload_count_r + PAY_CNT_W'(1);
  assign emit_end          = (length_r == '0) ? '0 : (length_r[PAY_CNT_W-1:0] - PAY_CNT_W'(1));

  assign stat.eq_first  = (rx_byte == magic_first_r);
  assign stat.eq_second = (rx_byte == magic_second_r);
  assign stat.hdr_last  = (header_count_r == HDR_CNT_W'(HEADER_BYTES - 1));
  assign stat.len_bad   = (len_hdr > {{(LEN_W-PAY_CNT_W){1'b0}}, limit});
  assign stat.len_zero  = (len_hdr == '0);
  assign stat.pay_last  = ({{(LEN_W-PAY_CNT_W){1'b0}}, payload_count_nxt} >= length_r);
  assign stat.crc_ok    = ({rx_byte, crc_low_r} == crc_r);
  assign stat.emit_last = ({1'b0, emit_idx_r} == emit_end);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
      max_payload_r  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_data;
        CFG_MAGIC_SECOND: magic_second_r <= cfg_data;
        CFG_MAX_PAYLOAD:  max_payload_r  <= cfg_data[PAY_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r  <= '0;
      payload_count_r <= '0;
      length_r        <= '0;
      crc_r           <= CRC_INIT;
      crc_low_r       <= '0;
      emit_idx_r      <= '0;
    end else begin
      if (cmd.frame_start) begin
        header_count_r  <= '0;
        payload_count_r <= '0;
        length_r        <= '0;
        crc_r           <= CRC_INIT;
      end
      if (cmd.hdr_wr) begin
        header_count_r <= header_count_r + HDR_CNT_W'(1);
        crc_r          <= crc_byte(crc_r, rx_byte);
        if (stat.hdr_last) begin
          length_r <= len_hdr;
        end
      end
      if (cmd.pay_wr) begin
        payload_count_r <= payload_count_nxt;
        crc_r           <= crc_byte(crc_r, rx_byte);
      end
      if (cmd.crc_lo_wr) begin
        crc_low_r <= rx_byte;
      end
      if (cmd.emit_start) begin
        emit_idx_r <= '0;
      end else if (cmd.emit_load) begin
        emit_idx_r <= emit_idx_r + OFFSET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_wr) begin
      hdr_r[header_count_r[2:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pay_wr) begin
      pay_mem[payload_count_r[AW-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r   <= '0;
      sync_err_r <= '0;
      crc_err_r  <= '0;
      len_err_r  <= '0;
    end else begin
      if (cmd.inc_frame) frames_r <= frames_r + CNT_W'(1);
      if (cmd.inc_sync) sync_err_r <= sync_err_r + CNT_W'(1);
      if (cmd.inc_crc) crc_err_r <= crc_err_r + CNT_W'(1);
      if (cmd.inc_len) len_err_r <= len_err_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload read lands directly in the result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_byte_r   <= '0;
      out_offset_r <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_load) begin
      out_status_r <= ST_READY;
      out_byte_r   <= (length_r == '0) ? 8'h00 : pay_mem[emit_idx_r[AW-1:0]];
      out_offset_r <= emit_idx_r;
      out_last_r   <= stat.emit_last;
    end
  end

  // Header and counters change only on a transaction that reloads the result register
  // or (frame count) leaves it empty, so they are shown straight from their registers.
  assign ready_res = (out_status_r == ST_READY);

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_header_word          = ready_res ? {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]} : '0;
  assign out_request_tag          = ready_res ? {hdr_r[5], hdr_r[4]} : '0;
  assign out_frame_payload_length = ready_res ? length_r[PAY_CNT_W-1:0] : '0;
  assign out_payload_byte         = out_byte_r;
  assign out_payload_offset       = out_offset_r;
  assign out_last_of_run          = out_last_r;
  assign out_frames_count         = frames_r;
  assign out_sync_error_count     = sync_err_r;
  assign out_crc_error_count      = crc_err_r;
  assign out_length_error_count   = len_err_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load || cmd.emit_load) |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an undelivered result");

  a_hdr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hdr_wr |-> (header_count_r < HDR_CNT_W'(HEADER_BYTES)))
    else $error("header write past the header store");

  a_pay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pay_wr |-> (payload_count_r < DEPTH_C))
    else $error("payload write past the payload store");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && cmd.emit_load))
    else $error("single result and burst result loaded together");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && stat.emit_last) |=> (out_last_r && out_status_r == ST_READY))
    else $error("final burst result lacks the last mark");
`endif

endmodule

`default_nettype wire
